### design/fklp_pkg.sv
// ----------------------------------------------------------------------------
// fklp_pkg: shared definitions of the flag keyword list parser
// Keyword table, flag bit constants and the operation passed from the
// front end to the back end through the queue.
// ----------------------------------------------------------------------------
package fklp_pkg;

  localparam int TABLE_SIZE = 38;
  localparam int NAME_COUNT_DEF = 38;
  localparam int QUEUE_DEPTH = 2;
  localparam int MASK_W = 18;
  localparam int POS_W = 4;
  localparam int MAX_CHARS = 16;

  localparam logic [POS_W-1:0] POS_MAX = 4'd15;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [MASK_W-1:0] F_NONE    = 18'h00000;
  localparam logic [MASK_W-1:0] F_COMPR   = 18'h00004;
  localparam logic [MASK_W-1:0] F_SYNC    = 18'h00008;
  localparam logic [MASK_W-1:0] F_IMMUT   = 18'h00010;
  localparam logic [MASK_W-1:0] F_APPEND  = 18'h00020;
  localparam logic [MASK_W-1:0] F_NODUMP  = 18'h00040;
  localparam logic [MASK_W-1:0] F_NOATIME = 18'h00080;
  localparam logic [MASK_W-1:0] F_DIRSYNC = 18'h10000;
  localparam logic [MASK_W-1:0] F_TOPDIR  = 18'h20000;

  typedef struct packed {
    logic [95:0]       text;
    logic [POS_W-1:0]  len;
    logic [MASK_W-1:0] set_bits;
    logic [MASK_W-1:0] clr_bits;
  } kw_t;

  typedef logic [MAX_CHARS-1:0][7:0] kw_chars_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       take;
    logic       blank;
    logic       fin;
    logic       last;
  } op_t;

  function automatic kw_t kw_entry(input int idx);
    kw_t e;
    e = '0;
    unique case (idx)
      0:  e = '{"nodump",       4'd6,  F_NODUMP,  F_NONE};
      1:  e = '{"dump",         4'd4,  F_NONE,    F_NODUMP};
      2:  e = '{"uappnd",       4'd6,  F_APPEND,  F_NONE};
      3:  e = '{"uappend",      4'd7,  F_APPEND,  F_NONE};
      4:  e = '{"appnd",        4'd5,  F_APPEND,  F_NONE};
      5:  e = '{"append",       4'd6,  F_APPEND,  F_NONE};
      6:  e = '{"sappnd",       4'd6,  F_APPEND,  F_NONE};
      7:  e = '{"sappend",      4'd7,  F_APPEND,  F_NONE};
      8:  e = '{"nouappnd",     4'd8,  F_NONE,    F_APPEND};
      9:  e = '{"nouappend",    4'd9,  F_NONE,    F_APPEND};
      10: e = '{"noappnd",      4'd7,  F_NONE,    F_APPEND};
      11: e = '{"noappend",     4'd8,  F_NONE,    F_APPEND};
      12: e = '{"nosappnd",     4'd8,  F_NONE,    F_APPEND};
      13: e = '{"nosappend",    4'd9,  F_NONE,    F_APPEND};
      14: e = '{"uchg",         4'd4,  F_IMMUT,   F_NONE};
      15: e = '{"uimmutable",   4'd10, F_IMMUT,   F_NONE};
      16: e = '{"chg",          4'd3,  F_IMMUT,   F_NONE};
      17: e = '{"immutable",    4'd9,  F_IMMUT,   F_NONE};
      18: e = '{"schg",         4'd4,  F_IMMUT,   F_NONE};
      19: e = '{"simmutable",   4'd10, F_IMMUT,   F_NONE};
      20: e = '{"nouchg",       4'd6,  F_NONE,    F_IMMUT};
      21: e = '{"nouimmutable", 4'd12, F_NONE,    F_IMMUT};
      22: e = '{"nochg",        4'd5,  F_NONE,    F_IMMUT};
      23: e = '{"noimmutable",  4'd11, F_NONE,    F_IMMUT};
      24: e = '{"noschg",       4'd6,  F_NONE,    F_IMMUT};
      25: e = '{"nosimmutable", 4'd12, F_NONE,    F_IMMUT};
      26: e = '{"noatime",      4'd7,  F_NOATIME, F_NONE};
      27: e = '{"atime",        4'd5,  F_NONE,    F_NOATIME};
      28: e = '{"sync",         4'd4,  F_SYNC,    F_NONE};
      29: e = '{"nosync",       4'd6,  F_NONE,    F_SYNC};
      30: e = '{"dirsync",      4'd7,  F_DIRSYNC, F_NONE};
      31: e = '{"nodirsync",    4'd9,  F_NONE,    F_DIRSYNC};
      32: e = '{"topdir",       4'd6,  F_TOPDIR,  F_NONE};
      33: e = '{"notopdir",     4'd8,  F_NONE,    F_TOPDIR};
      34: e = '{"compr",        4'd5,  F_COMPR,   F_NONE};
      35: e = '{"compress",     4'd8,  F_COMPR,   F_NONE};
      36: e = '{"nocompr",      4'd7,  F_NONE,    F_COMPR};
      37: e = '{"nocompress",   4'd10, F_NONE,    F_COMPR};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Entry p holds the keyword byte at token position p, zero past the end.
  function automatic kw_chars_t kw_chars(input int idx);
    kw_t e;
    kw_chars_t r;
    int n;
    e = kw_entry(idx);
    r = '0;
    n = int'(e.len);
    for (int p = 0; p < MAX_CHARS; p++) begin
      if (p < n) begin
        r[p] = e.text[(n-1-p)*8 +: 8];
      end
    end
    return r;
  endfunction

endpackage

### design/fklp_fifo.sv
// ----------------------------------------------------------------------------
// fklp_fifo: small register queue
// Decouples the classifying front end from the matching back end.
// ----------------------------------------------------------------------------
module fklp_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = fklp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### design/fklp_front.sv
// ----------------------------------------------------------------------------
// fklp_front: byte classifier
// Accepts string bytes, tracks the string end and turns each byte up to a zero
// byte, and the last byte, into a take, finish or result op for the back end.
// ----------------------------------------------------------------------------
module fklp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char_byte,
  input  logic             in_is_last,
  output logic             op_valid,
  input  logic             op_ready,
  output fklp_pkg::op_t    op_data
);

  logic ended_r, ended_nxt;
  logic accept, is_nul, is_comma, is_blank;

  assign accept   = in_valid && in_ready;
  assign is_nul   = (in_char_byte == fklp_pkg::CHAR_NUL);
  assign is_comma = (in_char_byte == fklp_pkg::CHAR_COMMA);
  assign is_blank = (in_char_byte == fklp_pkg::CHAR_SPACE) ||
                    ((in_char_byte >= fklp_pkg::CHAR_TAB) &&
                     (in_char_byte <= fklp_pkg::CHAR_CR));

  always_comb begin
    op_data.char_byte = in_char_byte;
    op_data.blank     = is_blank;
    op_data.last      = in_is_last;
    op_data.take      = !ended_r && !is_nul && !is_comma;
    op_data.fin       = !ended_r && (is_nul || is_comma || in_is_last);
  end

  assign in_ready = op_ready;
  assign op_valid = in_valid && (op_data.take || op_data.fin || op_data.last);

  always_comb begin
    ended_nxt = ended_r;
    if (accept) begin
      if (in_is_last) begin
        ended_nxt = 1'b0;
      end else if (is_nul) begin
        ended_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
    end else begin
      ended_r <= ended_nxt;
    end
  end

endmodule

### design/fklp_back.sv
// ----------------------------------------------------------------------------
// fklp_back: keyword matcher and accumulator
// Narrows the candidate set per byte, checks lengths at the token end,
// accumulates the masks and holds the result in an output register.
// ----------------------------------------------------------------------------
module fklp_back #(
  parameter int NAME_COUNT = fklp_pkg::NAME_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  fklp_pkg::op_t               op_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fklp_pkg::MASK_W-1:0] out_set_mask,
  output logic [fklp_pkg::MASK_W-1:0] out_clear_mask,
  output logic                        out_status
);

  localparam int MW = fklp_pkg::MASK_W;
  localparam int PW = fklp_pkg::POS_W;

  logic [NAME_COUNT-1:0] hits_r, hits_nxt, hits_mid, same_vec, match_vec;
  logic [PW-1:0]         pos_r, pos_nxt, pos_mid;
  logic                  body_r, body_nxt, body_mid;
  logic                  started_r, started_nxt, started_mid;
  logic [MW-1:0]         set_r, set_nxt, clr_r, clr_nxt;
  logic                  err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MW-1:0]         out_set_r, out_clr_r;
  logic                  out_status_r;
  logic [MW-1:0]         set_sel [NAME_COUNT];
  logic [MW-1:0]         clr_sel [NAME_COUNT];
  logic [MW-1:0]         set_hit, clr_hit;
  logic                  pop, step;

  genvar gi;
  generate
    for (gi = 0; gi < NAME_COUNT; gi++) begin : g_name
      if (gi < fklp_pkg::TABLE_SIZE) begin : g_used
        localparam fklp_pkg::kw_t       KW = fklp_pkg::kw_entry(gi);
        localparam fklp_pkg::kw_chars_t CH = fklp_pkg::kw_chars(gi);
        assign same_vec[gi]  = (CH[pos_r] == op_data.char_byte);
        assign match_vec[gi] = hits_mid[gi] && (KW.len == pos_mid);
        assign set_sel[gi]   = match_vec[gi] ? KW.set_bits : '0;
        assign clr_sel[gi]   = match_vec[gi] ? KW.clr_bits : '0;
      end else begin : g_unused
        assign same_vec[gi]  = 1'b0;
        assign match_vec[gi] = 1'b0;
        assign set_sel[gi]   = '0;
        assign clr_sel[gi]   = '0;
      end
    end
  endgenerate

  always_comb begin
    set_hit = '0;
    clr_hit = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      set_hit = set_hit | set_sel[i];
      clr_hit = clr_hit | clr_sel[i];
    end
  end

  assign op_ready = !op_data.last || !out_valid_r || out_ready;
  assign pop      = op_valid && op_ready;
  assign step     = op_data.take && (body_r || !op_data.blank);

  always_comb begin
    started_mid = started_r | op_data.take;
    body_mid    = body_r;
    hits_mid    = hits_r;
    pos_mid     = pos_r;
    if (step) begin
      body_mid = 1'b1;
      hits_mid = hits_r & same_vec;
      pos_mid  = (pos_r == fklp_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
    end
  end

  always_comb begin
    hits_nxt      = hits_r;
    pos_nxt       = pos_r;
    body_nxt      = body_r;
    started_nxt   = started_r;
    set_nxt       = set_r;
    clr_nxt       = clr_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      hits_nxt    = hits_mid;
      pos_nxt     = pos_mid;
      body_nxt    = body_mid;
      started_nxt = started_mid;
      if (op_data.fin) begin
        if (!err_r && started_mid) begin
          if (body_mid && (match_vec != '0)) begin
            set_nxt = set_r | set_hit;
            clr_nxt = clr_r | clr_hit;
          end else begin
            err_nxt = 1'b1;
          end
        end
        hits_nxt    = '1;
        pos_nxt     = '0;
        body_nxt    = 1'b0;
        started_nxt = 1'b0;
      end
      if (op_data.last) begin
        out_valid_nxt = 1'b1;
        hits_nxt      = '1;
        pos_nxt       = '0;
        body_nxt      = 1'b0;
        started_nxt   = 1'b0;
        set_nxt       = '0;
        clr_nxt       = '0;
        err_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '1;
      pos_r       <= '0;
      body_r      <= 1'b0;
      started_r   <= 1'b0;
      set_r       <= '0;
      clr_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hits_r      <= hits_nxt;
      pos_r       <= pos_nxt;
      body_r      <= body_nxt;
      started_r   <= started_nxt;
      set_r       <= set_nxt;
      clr_r       <= clr_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op_data.last) begin
      out_set_r    <= (op_data.fin && !err_r) ? (set_r | set_hit) : set_r;
      out_clr_r    <= (op_data.fin && !err_r) ? (clr_r | clr_hit) : clr_r;
      out_status_r <= err_r || (op_data.fin && started_mid &&
                                !(body_mid && (match_vec != '0)));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_set_mask   = out_set_r;
  assign out_clear_mask = out_clr_r;
  assign out_status     = out_status_r;

endmodule

### design/flag_keyword_list_parser_core.sv
// ----------------------------------------------------------------------------
// flag_keyword_list_parser_core: comma-separated flag keyword parser
// Parses a byte stream of keywords into set and clear flag masks.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_char_byte, in_is_last) takes one
// string byte per transfer. Keywords are separated by commas, and a zero byte
// ends the string; bytes after it are ignored until in_is_last is seen.
// A transfer with in_is_last high closes the string and yields one result on
// the output channel (out_set_mask, out_clear_mask, out_status); status is
// set when a whitespace-only or unknown keyword occurred.
// Throughput is one byte per cycle while the back end is not held by a stalled
// result on the output. With an empty queue the last byte is written into the
// queue register, then moves through the matcher into the output register,
// where the result becomes valid. When the receiver stalls, bytes keep
// flowing until a second last byte reaches the matcher and the queue fills;
// then in_ready drops.
// Reset empties the queue, clears the parser state and drops out_valid.
// ----------------------------------------------------------------------------
module flag_keyword_list_parser_core #(
  parameter int NAME_COUNT = fklp_pkg::NAME_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_char_byte,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fklp_pkg::MASK_W-1:0] out_set_mask,
  output logic [fklp_pkg::MASK_W-1:0] out_clear_mask,
  output logic                        out_status
);

  localparam int OP_W = $bits(fklp_pkg::op_t);

  fklp_pkg::op_t front_op, back_op;
  logic          front_valid, front_ready, back_valid, back_ready;
  logic [OP_W-1:0] back_bits;

  fklp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .in_is_last   (in_is_last),
    .op_valid     (front_valid),
    .op_ready     (front_ready),
    .op_data      (front_op)
  );

  fklp_fifo #(
    .WIDTH (OP_W),
    .DEPTH (fklp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_op),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_bits)
  );

  assign back_op = back_bits;

  fklp_back #(
    .NAME_COUNT (NAME_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (back_valid),
    .op_ready       (back_ready),
    .op_data        (back_op),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_set_mask   (out_set_mask),
    .out_clear_mask (out_clear_mask),
    .out_status     (out_status)
  );

endmodule

### tb/flag_keyword_list_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flag_keyword_list_parser_core_test: testbench of the flag keyword parser
// Sends directed and random keyword lists one byte per transfer, with bursts
// and gaps on the input and stall patterns on the output. Results are checked
// field by field against given directed flags, else a byte-level parser model.
// ----------------------------------------------------------------------------
module flag_keyword_list_parser_core_test;

  localparam int MW = fklp_pkg::MASK_W;
  localparam int KW_COUNT = 38;
  localparam int DIR_ROWS = 22;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 30;
  localparam logic [MW-1:0] F_NONE = fklp_pkg::F_NONE;
  localparam logic [MW-1:0] ALL_FLAGS = fklp_pkg::F_NODUMP | fklp_pkg::F_APPEND |
                                        fklp_pkg::F_IMMUT | fklp_pkg::F_NOATIME |
                                        fklp_pkg::F_SYNC | fklp_pkg::F_DIRSYNC |
                                        fklp_pkg::F_TOPDIR | fklp_pkg::F_COMPR;

  typedef struct packed {
    logic [MW-1:0] set_m;
    logic [MW-1:0] clr_m;
    logic          status;
  } flags_t;

  typedef struct {
    string         name;
    logic [MW-1:0] set_bits;
    logic [MW-1:0] clr_bits;
  } keyword_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    flags_t     typed_flags;
  } stim_t;

  typedef enum logic [1:0] {END_ON_TEXT, END_NUL, END_NUL_JUNK} string_end_t;

  typedef struct {
    string       text;
    string_end_t term;
    bit          typed;
    flags_t      flags;
  } dir_row_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

  keyword_t keywords [KW_COUNT] = '{
    '{"nodump", fklp_pkg::F_NODUMP, F_NONE},
    '{"dump", F_NONE, fklp_pkg::F_NODUMP},
    '{"uappnd", fklp_pkg::F_APPEND, F_NONE},
    '{"uappend", fklp_pkg::F_APPEND, F_NONE},
    '{"appnd", fklp_pkg::F_APPEND, F_NONE},
    '{"append", fklp_pkg::F_APPEND, F_NONE},
    '{"sappnd", fklp_pkg::F_APPEND, F_NONE},
    '{"sappend", fklp_pkg::F_APPEND, F_NONE},
    '{"nouappnd", F_NONE, fklp_pkg::F_APPEND},
    '{"nouappend", F_NONE, fklp_pkg::F_APPEND},
    '{"noappnd", F_NONE, fklp_pkg::F_APPEND},
    '{"noappend", F_NONE, fklp_pkg::F_APPEND},
    '{"nosappnd", F_NONE, fklp_pkg::F_APPEND},
    '{"nosappend", F_NONE, fklp_pkg::F_APPEND},
    '{"uchg", fklp_pkg::F_IMMUT, F_NONE},
    '{"uimmutable", fklp_pkg::F_IMMUT, F_NONE},
    '{"chg", fklp_pkg::F_IMMUT, F_NONE},
    '{"immutable", fklp_pkg::F_IMMUT, F_NONE},
    '{"schg", fklp_pkg::F_IMMUT, F_NONE},
    '{"simmutable", fklp_pkg::F_IMMUT, F_NONE},
    '{"nouchg", F_NONE, fklp_pkg::F_IMMUT},
    '{"nouimmutable", F_NONE, fklp_pkg::F_IMMUT},
    '{"nochg", F_NONE, fklp_pkg::F_IMMUT},
    '{"noimmutable", F_NONE, fklp_pkg::F_IMMUT},
    '{"noschg", F_NONE, fklp_pkg::F_IMMUT},
    '{"nosimmutable", F_NONE, fklp_pkg::F_IMMUT},
    '{"noatime", fklp_pkg::F_NOATIME, F_NONE},
    '{"atime", F_NONE, fklp_pkg::F_NOATIME},
    '{"sync", fklp_pkg::F_SYNC, F_NONE},
    '{"nosync", F_NONE, fklp_pkg::F_SYNC},
    '{"dirsync", fklp_pkg::F_DIRSYNC, F_NONE},
    '{"nodirsync", F_NONE, fklp_pkg::F_DIRSYNC},
    '{"topdir", fklp_pkg::F_TOPDIR, F_NONE},
    '{"notopdir", F_NONE, fklp_pkg::F_TOPDIR},
    '{"compr", fklp_pkg::F_COMPR, F_NONE},
    '{"compress", fklp_pkg::F_COMPR, F_NONE},
    '{"nocompr", F_NONE, fklp_pkg::F_COMPR},
    '{"nocompress", F_NONE, fklp_pkg::F_COMPR}
  };

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{"nodump", END_ON_TEXT, 1'b1, '{fklp_pkg::F_NODUMP, F_NONE, 1'b0}},
    '{"", END_NUL, 1'b1, '{F_NONE, F_NONE, 1'b0}},
    '{",,sync,,", END_NUL, 1'b1, '{fklp_pkg::F_SYNC, F_NONE, 1'b0}},
    '{"   ", END_NUL, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"bogus", END_ON_TEXT, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"sync,bogus,topdir", END_ON_TEXT, 1'b1, '{fklp_pkg::F_SYNC, F_NONE, 1'b1}},
    '{"nodump,uappnd,chg,noatime,sync,dirsync,topdir,compr", END_NUL, 1'b1,
      '{ALL_FLAGS, F_NONE, 1'b0}},
    '{"dump,noappend,nochg,atime,nosync,nodirsync,notopdir,nocompress", END_ON_TEXT, 1'b1,
      '{F_NONE, ALL_FLAGS, 1'b0}},
    '{"nosimmutable,nouimmutable", END_ON_TEXT, 1'b0, '0},
    '{"nouimmutablexxxx", END_NUL, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"\011\012\013\014\015 append", END_ON_TEXT, 1'b0, '0},
    '{"app end", END_ON_TEXT, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"sync", END_NUL_JUNK, 1'b0, '0},
    '{"chg,", END_ON_TEXT, 1'b0, '0},
    '{"uchg,schg,uimmutable,simmutable,immutable", END_NUL, 1'b0, '0},
    '{"sappnd,sappend,uappend,appnd,append,nouappnd,nouappend,noappnd,nosappnd,nosappend",
      END_ON_TEXT, 1'b0, '0},
    '{"nouchg,noimmutable,noschg,compress,nocompr", END_ON_TEXT, 1'b0, '0},
    '{"SYNC", END_ON_TEXT, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"syn", END_ON_TEXT, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"syncs", END_NUL, 1'b1, '{F_NONE, F_NONE, 1'b1}},
    '{"dump, ,sync", END_ON_TEXT, 1'b1, '{F_NONE, fklp_pkg::F_NODUMP, 1'b1}},
    '{",,,", END_ON_TEXT, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_char_byte;
  logic in_is_last;
  logic out_valid;
  logic out_ready;
  logic [MW-1:0] out_set_mask;
  logic [MW-1:0] out_clear_mask;
  logic out_status;

  stim_t stim_q[$];
  flags_t expected_flags_q[$];
  flags_t predicted;
  flags_t oldest;
  int accept_idx = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;

  logic [KW_COUNT-1:0] tok_cand;
  logic [fklp_pkg::POS_W-1:0] tok_pos;
  bit tok_body;
  bit tok_started;
  bit list_error;
  bit list_ended;
  logic [MW-1:0] acc_set;
  logic [MW-1:0] acc_clr;

  flag_keyword_list_parser_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_byte  (in_char_byte),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_set_mask  (out_set_mask),
    .out_clear_mask(out_clear_mask),
    .out_status    (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_blank_byte(input logic [7:0] c);
    return c == fklp_pkg::CHAR_SPACE ||
           (c >= fklp_pkg::CHAR_TAB && c <= fklp_pkg::CHAR_CR);
  endfunction

  function automatic void clear_token_state();
    tok_cand = '1;
    tok_pos = '0;
    tok_body = 1'b0;
    tok_started = 1'b0;
  endfunction

  function automatic void reset_parser_state();
    clear_token_state();
    acc_set = '0;
    acc_clr = '0;
    list_error = 1'b0;
    list_ended = 1'b0;
  endfunction

  function automatic void close_token();
    bit found;
    found = 1'b0;
    if (!list_error && tok_started) begin
      if (tok_body) begin
        for (int i = 0; i < KW_COUNT; i++) begin
          if (!found && tok_cand[i] && keywords[i].name.len() == int'(tok_pos)) begin
            acc_set |= keywords[i].set_bits;
            acc_clr |= keywords[i].clr_bits;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        list_error = 1'b1;
      end
    end
    clear_token_state();
  endfunction

  function automatic bit parse_byte(input logic [7:0] c, input logic last, output flags_t r);
    r = '0;
    if (!list_ended) begin
      if (c == fklp_pkg::CHAR_NUL) begin
        close_token();
        list_ended = 1'b1;
      end else if (c == fklp_pkg::CHAR_COMMA) begin
        close_token();
      end else begin
        tok_started = 1'b1;
        if (tok_body || !is_blank_byte(c)) begin
          tok_body = 1'b1;
          for (int i = 0; i < KW_COUNT; i++) begin
            if (!(int'(tok_pos) < keywords[i].name.len() &&
                  keywords[i].name[tok_pos] == c)) begin
              tok_cand[i] = 1'b0;
            end
          end
          if (tok_pos != fklp_pkg::POS_MAX) begin
            tok_pos++;
          end
        end
      end
    end
    if (!last) begin
      return 1'b0;
    end
    if (!list_ended) begin
      close_token();
    end
    r.set_m = acc_set;
    r.clr_m = acc_clr;
    r.status = list_error;
    reset_parser_state();
    return 1'b1;
  endfunction

  function automatic logic [7:0] random_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? fklp_pkg::CHAR_SPACE : fklp_pkg::CHAR_TAB + 8'(k - 1);
  endfunction

  function automatic logic [7:0] random_letter();
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic void push_byte(input logic [7:0] c);
    stim_t e;
    e.ch = c;
    e.last = 1'b0;
    e.typed = 1'b0;
    e.typed_flags = '0;
    stim_q.push_back(e);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endfunction

  function automatic void mark_last(input bit typed, input flags_t f);
    stim_q[stim_q.size()-1].last = 1'b1;
    stim_q[stim_q.size()-1].typed = typed;
    stim_q[stim_q.size()-1].typed_flags = f;
  endfunction

  function automatic void add_random_string();
    int start;
    int n_tok;
    int pick;
    int len;
    int end_kind;
    string s;
    start = stim_q.size();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      mark_last(1'b0, '0);
      return;
    end
    n_tok = $urandom_range(1, 4);
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0) begin
        push_byte(fklp_pkg::CHAR_COMMA);
      end
      pick = $urandom_range(0, 99);
      s = keywords[$urandom_range(0, KW_COUNT - 1)].name;
      len = s.len();
      if (pick < 8) begin
      end else if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) push_byte(random_blank());
        end
        push_text(s);
      end else if (pick < 73) begin
        s[$urandom_range(0, len - 1)] = random_letter();
        push_text(s);
      end else if (pick < 76) begin
        push_text(s);
        push_byte(random_letter());
      end else if (pick < 78) begin
        push_text(s.substr(0, len - 2));
      end else if (pick < 80) begin
        push_text(s.substr(0, 0));
        push_byte(random_blank());
        push_text(s.substr(1, len - 1));
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 4)) push_byte(random_blank());
      end else if (pick < 93) begin
        repeat ($urandom_range(13, 20)) push_byte(random_letter());
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(1, 255)));
      end
    end
    end_kind = $urandom_range(0, 99);
    if (end_kind < 40 && stim_q.size() > start) begin
      mark_last(1'b0, '0);
    end else if (end_kind < 70) begin
      push_byte(fklp_pkg::CHAR_NUL);
      mark_last(1'b0, '0);
    end else if (end_kind < 85) begin
      push_byte(fklp_pkg::CHAR_NUL);
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      mark_last(1'b0, '0);
    end else begin
      push_byte(fklp_pkg::CHAR_COMMA);
      mark_last(1'b0, '0);
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (parse_byte(in_char_byte, in_is_last, predicted)) begin
        if (stim_q[accept_idx].typed) begin
          expected_flags_q.push_back(stim_q[accept_idx].typed_flags);
        end else begin
          expected_flags_q.push_back(predicted);
        end
      end
      accept_idx++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_flags_q.size() == 0) begin
        $error("unexpected result: set_mask %05h, clear_mask %05h, status %b",
               out_set_mask, out_clear_mask, out_status);
        fail_count++;
      end else begin
        oldest = expected_flags_q.pop_front();
        if (out_set_mask !== oldest.set_m) begin
          $error("set_mask: expected %05h, actual %05h", oldest.set_m, out_set_mask);
          fail_count++;
        end
        if (out_clear_mask !== oldest.clr_m) begin
          $error("clear_mask: expected %05h, actual %05h", oldest.clr_m, out_clear_mask);
          fail_count++;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %b, actual %b", oldest.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    ready_mode_t mode;
    int span;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 64);
      repeat (span) begin
        if (!held && results_seen >= HOLD_AFTER) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          RDY_ALWAYS: out_ready <= 1'b1;
          RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= ~out_ready;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    int pause_at;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_byte <= 8'h00;
    in_is_last <= 1'b0;
    reset_parser_state();
    foreach (dir_rows[r]) begin
      push_text(dir_rows[r].text);
      if (dir_rows[r].term != END_ON_TEXT) begin
        push_byte(fklp_pkg::CHAR_NUL);
      end
      if (dir_rows[r].term == END_NUL_JUNK) begin
        push_text("x, ,bogus");
      end
      mark_last(dir_rows[r].typed, dir_rows[r].flags);
    end
    pause_at = stim_q.size();
    while (stim_q.size() < pause_at + RANDOM_ITEMS) begin
      add_random_string();
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = 0;
    for (int k = 0; k < stim_q.size(); k++) begin
      if (k == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_flags_q.size() != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                   $urandom_range(1, 16);
      end
      burst_left--;
      in_valid <= 1'b1;
      in_char_byte <= stim_q[k].ch;
      in_is_last <= stim_q[k].last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    while (expected_flags_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
design/fklp_pkg.sv
design/fklp_fifo.sv
design/fklp_front.sv
design/fklp_back.sv
design/flag_keyword_list_parser_core.sv
tb/flag_keyword_list_parser_core_test.sv
